/* hdl/assert_macros.svh */
// Assertion macros shared by the escaper RTL files.
// Depends on nothing; included by each module that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that expr holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: %m");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: %m");

`endif

/* hdl/dns_esc_pkg.sv */
// Types and character constants of the DNS text-string escaper.
// Depends on nothing; used by dns_esc_expand, dns_esc_serial and the top level.
`default_nettype none

package dns_esc_pkg;

  localparam int MAX_CHARS = 5;
  localparam int CNT_W     = 3;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LOW    = 8'h20;
  localparam logic [7:0] CH_HIGH   = 8'h7E;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef struct packed {
    logic [7:0] out_char;
    logic       string_done;
    logic       length_error;
  } char_res_t;

  typedef struct packed {
    char_res_t [MAX_CHARS-1:0] chars;
    logic [CNT_W-1:0]          count;
  } burst_t;

endpackage

`default_nettype wire

/* hdl/dns_esc_if.sv */
// Valid/ready channel interfaces of the escaper: input bytes and output characters.
// Depends on nothing.
`default_nettype none

interface dns_esc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;

  modport source (output valid, output data_byte, output end_of_data, input ready);
  modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface dns_esc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       string_done;
  logic       length_error;

  modport source (output valid, output out_char, output string_done,
                  output length_error, input ready);
  modport sink   (input valid, input out_char, input string_done,
                  input length_error, output ready);
endinterface

`default_nettype wire

/* hdl/dns_esc_expand.sv */
// String phase tracking and expansion of one input byte into its character burst.
// Depends on dns_esc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dns_esc_expand (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_fire,
  input  wire logic [7:0]          data_byte,
  input  wire logic                end_of_data,
  output dns_esc_pkg::burst_t      burst
);
  import dns_esc_pkg::*;

  logic       in_body;
  logic [7:0] bytes_left;
  logic       in_body_next;
  logic [7:0] bytes_left_next;

  logic [1:0]  hundreds;
  logic [7:0]  rem_full;
  logic [6:0]  rem;
  logic [14:0] prod;
  logic [3:0]  tens;
  logic [6:0]  ones;

  char_res_t [MAX_CHARS-1:0] esc;
  logic [CNT_W-1:0]          n_esc;
  char_res_t                 tail;
  logic                      has_tail;
  logic [7:0]                left_dec;
  logic                      length_phase;

  always_comb begin
    if (data_byte >= 8'd200) begin
      hundreds = 2'd2;
    end else if (data_byte >= 8'd100) begin
      hundreds = 2'd1;
    end else begin
      hundreds = 2'd0;
    end
    rem_full = data_byte - 8'(hundreds * 8'd100);
    rem      = rem_full[6:0];
    prod     = {8'd0, rem} * 15'd205;
    tens     = prod[14:11];
    ones     = rem - 7'(tens * 7'd10);
  end

  always_comb begin
    length_phase    = !in_body || (bytes_left == 8'd0);
    left_dec        = bytes_left - 8'd1;
    esc             = '0;
    n_esc           = '0;
    tail            = '0;
    has_tail        = 1'b0;
    in_body_next    = in_body;
    bytes_left_next = bytes_left;

    if (length_phase) begin
      esc[0].out_char = CH_QUOTE;
      n_esc           = CNT_W'(1);
      if (data_byte == 8'd0) begin
        tail            = '{out_char: CH_QUOTE, string_done: 1'b1, length_error: 1'b0};
        has_tail        = 1'b1;
        in_body_next    = 1'b0;
        bytes_left_next = 8'd0;
      end else if (end_of_data) begin
        tail            = '{out_char: CH_NUL, string_done: 1'b1, length_error: 1'b1};
        has_tail        = 1'b1;
        in_body_next    = 1'b0;
        bytes_left_next = 8'd0;
      end else begin
        in_body_next    = 1'b1;
        bytes_left_next = data_byte;
      end
    end else begin
      if (data_byte >= CH_LOW && data_byte <= CH_HIGH) begin
        if (data_byte == CH_BSLASH || data_byte == CH_QUOTE) begin
          esc[0].out_char = CH_BSLASH;
          esc[1].out_char = data_byte;
          n_esc           = CNT_W'(2);
        end else begin
          esc[0].out_char = data_byte;
          n_esc           = CNT_W'(1);
        end
      end else begin
        esc[0].out_char = CH_BSLASH;
        esc[1].out_char = CH_ZERO + {6'd0, hundreds};
        esc[2].out_char = CH_ZERO + {4'd0, tens};
        esc[3].out_char = CH_ZERO + {1'b0, ones};
        n_esc           = CNT_W'(4);
      end
      bytes_left_next = left_dec;
      if (left_dec == 8'd0) begin
        tail         = '{out_char: CH_QUOTE, string_done: 1'b1, length_error: 1'b0};
        has_tail     = 1'b1;
        in_body_next = 1'b0;
      end else if (end_of_data) begin
        tail            = '{out_char: CH_NUL, string_done: 1'b1, length_error: 1'b1};
        has_tail        = 1'b1;
        in_body_next    = 1'b0;
        bytes_left_next = 8'd0;
      end
    end
  end

  always_comb begin
    burst.count = n_esc + CNT_W'(has_tail);
    for (int i = 0; i < MAX_CHARS; i++) begin
      if (CNT_W'(i) < n_esc) begin
        burst.chars[i] = esc[i];
      end else if (CNT_W'(i) == n_esc && has_tail) begin
        burst.chars[i] = tail;
      end else begin
        burst.chars[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_body    <= 1'b0;
      bytes_left <= 8'd0;
    end else if (in_fire) begin
      in_body    <= in_body_next;
      bytes_left <= bytes_left_next;
    end
  end

  `ASSERT_ALWAYS(a_body_count_live, clk, rst, !in_body || bytes_left != 8'd0)

endmodule

`default_nettype wire

/* hdl/dns_esc_serial.sv */
// Burst register and character serializer: holds one byte's characters, emits one per cycle while out_ready is high.
// Depends on dns_esc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dns_esc_serial (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire dns_esc_pkg::burst_t burst,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output dns_esc_pkg::char_res_t   out_res
);
  import dns_esc_pkg::*;

  burst_t           pending;
  logic             full;
  logic [CNT_W-1:0] slot;
  logic             at_last;
  logic             out_fire;
  logic             in_fire;

  assign at_last   = (slot == pending.count - CNT_W'(1));
  assign out_valid = full;
  assign out_res   = pending.chars[slot];
  assign out_fire  = full && out_ready;
  assign in_ready  = !full || (out_fire && at_last);
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pending <= burst;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      slot <= '0;
    end else if (in_fire) begin
      full <= 1'b1;
      slot <= '0;
    end else if (out_fire) begin
      if (at_last) begin
        full <= 1'b0;
        slot <= '0;
      end else begin
        slot <= slot + CNT_W'(1);
      end
    end
  end

  `ASSERT_ALWAYS(a_slot_in_burst, clk, rst, !full || slot < pending.count)
  `ASSERT_NEXT(a_mid_burst_stays, clk, rst, out_fire && !at_last, full && slot != '0)

endmodule

`default_nettype wire

/* hdl/dns_text_string_escaper.sv */
// Top level of the DNS text-string escaper: byte input channel, character output channel.
// Depends on dns_esc_pkg, dns_esc_if, dns_esc_expand and dns_esc_serial.
//
// in_ch carries record-data bytes (data_byte, end_of_data). A byte in idle phase is
// a string length; in body phase it is a string byte that is escaped.
// out_ch carries presentation characters (out_char, string_done, length_error),
// with string_done on the closing quote or on the error word.
// Each accepted byte expands in one pass into a burst of 1 to 5 output words that
// is loaded into the burst register; the first word is offered on the cycle after
// acceptance.
// Words leave at one per cycle while out_ch.ready is high. A byte occupies the single
// burst register until the last word of its burst leaves, so bytes are taken every
// cycle only when each yields one word; the next byte is taken in the cycle the last
// word of a burst leaves.
// When the receiver stalls, the current word holds and in_ch.ready drops once the
// burst register holds an unfinished burst.
// Synchronous reset clears the phase to idle, the remaining count to zero and the
// burst register to empty.
`default_nettype none

module dns_text_string_escaper (
  input  wire logic      clk,
  input  wire logic      rst,
  dns_esc_in_if.sink     in_ch,
  dns_esc_out_if.source  out_ch
);
  import dns_esc_pkg::*;

  burst_t    burst;
  char_res_t out_res;
  logic      ser_ready;
  logic      in_fire;

  assign in_ch.ready = ser_ready;
  assign in_fire     = in_ch.valid && ser_ready;

  dns_esc_expand u_expand (
    .clk         (clk),
    .rst         (rst),
    .in_fire     (in_fire),
    .data_byte   (in_ch.data_byte),
    .end_of_data (in_ch.end_of_data),
    .burst       (burst)
  );

  dns_esc_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (ser_ready),
    .burst     (burst),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.out_char     = out_res.out_char;
  assign out_ch.string_done  = out_res.string_done;
  assign out_ch.length_error = out_res.length_error;

endmodule

`default_nettype wire
